// ===== rtl/core/bpdc_pkg.sv =====
`default_nettype none

package bpdc_pkg;

    localparam int CFG_W      = 15;
    localparam int HOLD_W     = 16;
    localparam int CLS_W      = 4;
    localparam int EVT_W      = 2;
    localparam int IDX_W      = 3;
    localparam int NUM_LEVELS = 5;
    localparam int HOLD_LIMIT = 30000;

    localparam logic [CFG_W-1:0] SHORT_TICKS_RST   = CFG_W'(5);
    localparam logic [CFG_W-1:0] LEVEL1_TICKS_RST  = CFG_W'(100);
    localparam logic [CFG_W-1:0] LEVEL2_TICKS_RST  = CFG_W'(200);
    localparam logic [CFG_W-1:0] LEVEL3_TICKS_RST  = CFG_W'(300);
    localparam logic [CFG_W-1:0] LEVEL4_TICKS_RST  = CFG_W'(400);
    localparam logic [CFG_W-1:0] LEVEL5_TICKS_RST  = CFG_W'(500);
    localparam logic [CFG_W-1:0] RELEASE_TICKS_RST = CFG_W'(10);
    localparam logic [CFG_W-1:0] IDLE_TICKS_RST    = CFG_W'(20);

    typedef enum logic [IDX_W-1:0] {
        REG_SHORT   = 3'd0,
        REG_LEVEL1  = 3'd1,
        REG_LEVEL2  = 3'd2,
        REG_LEVEL3  = 3'd3,
        REG_LEVEL4  = 3'd4,
        REG_LEVEL5  = 3'd5,
        REG_RELEASE = 3'd6,
        REG_IDLE    = 3'd7
    } t_reg_idx;

    typedef enum logic [CLS_W-1:0] {
        CLS_OFF        = 4'd0,
        CLS_STARTUP    = 4'd1,
        CLS_SHORT      = 4'd2,
        CLS_1S         = 4'd3,
        CLS_2S         = 4'd4,
        CLS_3S         = 4'd5,
        CLS_4S         = 4'd6,
        CLS_5S         = 4'd7,
        CLS_SHORT_DONE = 4'd8,
        CLS_1S_DONE    = 4'd9,
        CLS_2S_DONE    = 4'd10,
        CLS_3S_DONE    = 4'd11,
        CLS_4S_DONE    = 4'd12,
        CLS_5S_DONE    = 4'd13
    } t_class;

    localparam logic [CLS_W-1:0] CLS_DONE_OFS = CLS_SHORT_DONE - CLS_SHORT;

    typedef enum logic [EVT_W-1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_SLEEP = 2'd2
    } t_event;

    typedef struct packed {
        logic [CFG_W-1:0]                 short_ticks;
        logic [NUM_LEVELS-1:0][CFG_W-1:0] level_ticks;
        logic [CFG_W-1:0]                 release_ticks;
        logic [CFG_W-1:0]                 idle_ticks;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/core/bpdc_if.sv =====
`default_nettype none

interface bpdc_in_if;
    logic valid;
    logic ready;
    logic pressed;

    modport source (output valid, output pressed, input ready);
    modport sink (input valid, input pressed, output ready);
endinterface

interface bpdc_out_if
    import bpdc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [EVT_W-1:0]         event_res;
    logic [CLS_W-1:0]         press_class;
    logic signed [HOLD_W-1:0] hold_value;

    modport source (output valid, output event_res, output press_class, output hold_value,
                    input ready);
    modport sink (input valid, input event_res, input press_class, input hold_value,
                  output ready);
endinterface

interface bpdc_cfg_if
    import bpdc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/button_press_duration_classifier_core.sv =====
`default_nettype none

// Classifies the duration of button presses from one sampled level per input word.
// Every accepted word updates a saturating signed hold counter and the press class,
// and yields exactly one result word carrying the event, the new class and the counter.
// The result is held in the output register in the cycle after acceptance; a new word is
// taken every clock as long as the output register is empty or being read in the same
// cycle, so throughput is one word per clock, set by the single state/result register
// stage. Configuration writes are always ready and take effect on the next accepted word.

module button_press_duration_classifier_core
    import bpdc_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    bpdc_in_if.sink      i_in,
    bpdc_out_if.source   o_out,
    bpdc_cfg_if.sink     i_cfg
);

    localparam int EXT_W = HOLD_W + 1;
    localparam logic signed [EXT_W-1:0] LIM_POS = EXT_W'(HOLD_LIMIT);
    localparam logic signed [EXT_W-1:0] LIM_NEG = -LIM_POS;
    localparam logic signed [EXT_W-1:0] ONE     = EXT_W'(1);
    localparam logic signed [EXT_W-1:0] ZERO    = EXT_W'(0);

    t_cfg w_cfg;

    logic                     r_out_valid;
    logic signed [HOLD_W-1:0] r_hold;
    logic signed [HOLD_W-1:0] n_hold;
    t_class                   r_class;
    t_class                   n_class;
    t_event                   r_event;
    t_event                   n_event;

    logic                     w_in_acc;
    logic signed [EXT_W-1:0]  w_hold_ext;
    logic signed [EXT_W-1:0]  w_next_ext;
    logic signed [EXT_W-1:0]  w_neg_rel;
    logic signed [EXT_W-1:0]  w_neg_idle;
    logic signed [EXT_W-1:0]  w_short_ext;
    logic [NUM_LEVELS-1:0]    w_level_hit;

    bpdc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    assign i_in.ready        = !r_out_valid || o_out.ready;
    assign w_in_acc          = i_in.valid && i_in.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.event_res   = r_event;
    assign o_out.press_class = r_class;
    assign o_out.hold_value  = r_hold;

    // counter update
    always_comb begin
        w_hold_ext  = {r_hold[HOLD_W-1], r_hold};
        w_neg_rel   = -$signed({{(EXT_W-CFG_W){1'b0}}, w_cfg.release_ticks});
        w_neg_idle  = -$signed({{(EXT_W-CFG_W){1'b0}}, w_cfg.idle_ticks});
        w_short_ext = $signed({{(EXT_W-CFG_W){1'b0}}, w_cfg.short_ticks});
        if (i_in.pressed) begin
            if (w_hold_ext < w_neg_rel) begin
                w_next_ext = ONE;
            end else if (w_hold_ext < LIM_POS) begin
                w_next_ext = w_hold_ext + ONE;
            end else begin
                w_next_ext = w_hold_ext;
            end
        end else begin
            if (w_hold_ext > ZERO) begin
                w_next_ext = -ONE;
            end else if (w_hold_ext > LIM_NEG) begin
                w_next_ext = w_hold_ext - ONE;
            end else begin
                w_next_ext = w_hold_ext;
            end
        end
        n_hold = w_next_ext[HOLD_W-1:0];
        for (int k = 0; k < NUM_LEVELS; k++) begin
            w_level_hit[k] =
                w_next_ext == $signed({{(EXT_W-CFG_W){1'b0}}, w_cfg.level_ticks[k]});
        end
    end

    // class update and consumption of finished short and level-2 presses
    always_comb begin
        n_class = r_class;
        n_event = EVT_NONE;
        if (w_next_ext == w_neg_rel) begin
            if (r_class inside {[CLS_SHORT:CLS_5S]}) begin
                n_class = t_class'(r_class + CLS_DONE_OFS);
            end else begin
                n_class = CLS_OFF;
            end
        end else if (w_next_ext == w_neg_idle) begin
            n_class = CLS_OFF;
        end else if (w_next_ext == w_short_ext) begin
            n_class = CLS_SHORT;
        end else begin
            for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
                if (w_level_hit[k]) begin
                    n_class = t_class'(CLS_W'(int'(CLS_1S) + k));
                end
            end
        end
        case (n_class)
            CLS_SHORT_DONE: begin
                n_class = CLS_OFF;
                n_event = EVT_SHORT;
            end
            CLS_2S_DONE: begin
                n_class = CLS_OFF;
                n_event = EVT_SLEEP;
            end
            default: n_event = EVT_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hold      <= '0;
            r_class     <= CLS_STARTUP;
            r_event     <= EVT_NONE;
        end else begin
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
                r_hold      <= n_hold;
                r_class     <= n_class;
                r_event     <= n_event;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_hold_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold <= HOLD_W'(HOLD_LIMIT)) && (r_hold >= -HOLD_W'(HOLD_LIMIT)))
        else $error("hold counter beyond limit");

    a_event_clears_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event != EVT_NONE) |-> r_class == CLS_OFF)
        else $error("event word with class not off");

    a_no_consumed_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_class != CLS_SHORT_DONE && r_class != CLS_2S_DONE)
        else $error("consumed class left in state");

    a_release_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_in.pressed && r_hold > 0) |=> r_hold == -HOLD_W'(1))
        else $error("release after press did not restart counter");

endmodule

`default_nettype wire

// ===== rtl/core/bpdc_cfg_regs.sv =====
`default_nettype none

module bpdc_cfg_regs
    import bpdc_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    bpdc_cfg_if.sink     i_cfg,
    output t_cfg         o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_SHORT:   n_cfg.short_ticks    = i_cfg.wdata;
                REG_LEVEL1:  n_cfg.level_ticks[0] = i_cfg.wdata;
                REG_LEVEL2:  n_cfg.level_ticks[1] = i_cfg.wdata;
                REG_LEVEL3:  n_cfg.level_ticks[2] = i_cfg.wdata;
                REG_LEVEL4:  n_cfg.level_ticks[3] = i_cfg.wdata;
                REG_LEVEL5:  n_cfg.level_ticks[4] = i_cfg.wdata;
                REG_RELEASE: n_cfg.release_ticks  = i_cfg.wdata;
                REG_IDLE:    n_cfg.idle_ticks     = i_cfg.wdata;
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_ticks    <= SHORT_TICKS_RST;
            r_cfg.level_ticks[0] <= LEVEL1_TICKS_RST;
            r_cfg.level_ticks[1] <= LEVEL2_TICKS_RST;
            r_cfg.level_ticks[2] <= LEVEL3_TICKS_RST;
            r_cfg.level_ticks[3] <= LEVEL4_TICKS_RST;
            r_cfg.level_ticks[4] <= LEVEL5_TICKS_RST;
            r_cfg.release_ticks  <= RELEASE_TICKS_RST;
            r_cfg.idle_ticks     <= IDLE_TICKS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire
